// ===== rtl/npcm_pkg.sv =====
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette colour mapper.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned ColorW = 24;
  localparam int unsigned CountW = 9;
  localparam int unsigned DistW  = 18;  // 3 * 255^2 fits

  typedef enum logic [1:0] {
    FMT_RGB888 = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_RGB444 = 2'd2,
    FMT_SPARE  = 2'd3
  } pix_fmt_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_MAP  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    REG_COUNT  = 2'd0,
    REG_FORMAT = 2'd1,
    REG_NONE2  = 2'd2,
    REG_NONE3  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic              is_map;
    logic [SlotW-1:0]  slot;
    logic [ColorW-1:0] color;    // load colour or expanded pixel
    logic [CountW-1:0] count;    // entries to search
    logic [SlotW-1:0]  win_slot;
    logic [DistW-1:0]  win_err;
    logic              done;     // exact match seen
  } item_t;

endpackage

// ===== rtl/nearest_palette_color_mapper.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper
// Maps pixels to the nearest palette colour through a chain of palette cells.
// ----------------------------------------------------------------------------
// Each transaction passes through the registered cell chain before its result appears.
// Throughput: one transaction per cycle, load or map, unless a waiting result stalls the chain.
// Reset clears valid bits and registers (count 0, format RGB888); palette
// entries are undefined until loaded. No clearing pass.
module nearest_palette_color_mapper #(
  parameter int unsigned PALETTE_DEPTH = npcm_pkg::PaletteDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [7:0] entry_index, [31:8] pixel_word
  input  logic        s_axis_tuser,   // [0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] palette_index
);

  localparam logic [npcm_pkg::CountW-1:0] DepthC = npcm_pkg::CountW'(PALETTE_DEPTH);

  logic [8:0] count_q;
  logic [1:0] fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fmt_q   <= npcm_pkg::FMT_RGB888;
    end else if (cfg_we_i) begin
      case (npcm_pkg::reg_idx_e'(cfg_idx_i))
        npcm_pkg::REG_COUNT:  count_q <= cfg_data_i;
        npcm_pkg::REG_FORMAT: fmt_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Whole chain moves together; it stalls only when a finished result waits.
  logic adv;
  logic last_valid;
  npcm_pkg::item_t last_item;

  assign adv           = !(m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = adv;
  assign m_axis_tvalid = last_valid && last_item.is_map;
  assign m_axis_tdata  = last_item.win_slot;

  // entry item: map pixels widened here, search count saturated to depth
  logic [23:0] rgb;
  npcm_pkg::item_t head;

  npcm_unpack u_unpack (
    .fmt_i  (fmt_q),
    .word_i (s_axis_tdata[31:8]),
    .rgb_o  (rgb)
  );

  always_comb begin
    head.is_map   = (s_axis_tuser == npcm_pkg::REQ_MAP);
    head.slot     = s_axis_tdata[7:0];
    head.color    = head.is_map ? rgb : s_axis_tdata[31:8];
    head.count    = (count_q > DepthC) ? DepthC : count_q;
    head.win_slot = '0;
    head.win_err  = '1;  // above any real distance
    head.done     = 1'b0;
  end

  logic            v_chain [PALETTE_DEPTH+1];
  npcm_pkg::item_t i_chain [PALETTE_DEPTH+1];

  assign v_chain[0] = s_axis_tvalid;
  assign i_chain[0] = head;

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    npcm_cell #(.CellIdx(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (v_chain[k]),
      .item_i  (i_chain[k]),
      .valid_o (v_chain[k+1]),
      .item_o  (i_chain[k+1])
    );
  end

  assign last_valid = v_chain[PALETTE_DEPTH];
  assign last_item  = i_chain[PALETTE_DEPTH];

endmodule

// ===== rtl/npcm_unpack.sv =====
// ----------------------------------------------------------------------------
// npcm_unpack
// Expands an RGB565 / RGB444 pixel to RGB888 by bit replication; other formats pass through.
// ----------------------------------------------------------------------------
module npcm_unpack (
  input  logic [1:0]  fmt_i,
  input  logic [23:0] word_i,
  output logic [23:0] rgb_o
);

  logic [4:0] r5, b5;
  logic [5:0] g6;
  logic [3:0] r4, g4, b4;

  assign r5 = word_i[15:11];
  assign g6 = word_i[10:5];
  assign b5 = word_i[4:0];
  assign r4 = word_i[11:8];
  assign g4 = word_i[7:4];
  assign b4 = word_i[3:0];

  always_comb begin
    case (npcm_pkg::pix_fmt_e'(fmt_i))
      npcm_pkg::FMT_RGB565: rgb_o = {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
      npcm_pkg::FMT_RGB444: rgb_o = {r4, r4, g4, g4, b4, b4};
      default:              rgb_o = word_i;
    endcase
  end

endmodule

// ===== rtl/npcm_cell.sv =====
// ----------------------------------------------------------------------------
// npcm_cell
// One chain cell: holds one palette entry, updates the running best match.
// ----------------------------------------------------------------------------
module npcm_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  npcm_pkg::item_t  item_i,
  output logic             valid_o,
  output npcm_pkg::item_t  item_o
);

  localparam logic [npcm_pkg::SlotW-1:0]  IdxS = npcm_pkg::SlotW'(CellIdx);
  localparam logic [npcm_pkg::CountW-1:0] IdxC = npcm_pkg::CountW'(CellIdx);

  logic [23:0] pal_q;
  logic        valid_q;
  npcm_pkg::item_t item_q, item_d;

  logic [7:0]  dr, dg, db;
  logic [15:0] sr, sg, sb;
  logic [npcm_pkg::DistW-1:0] err_sum;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  assign dr = absdiff(item_i.color[23:16], pal_q[23:16]);
  assign dg = absdiff(item_i.color[15:8],  pal_q[15:8]);
  assign db = absdiff(item_i.color[7:0],   pal_q[7:0]);
  assign sr = dr * dr;
  assign sg = dg * dg;
  assign sb = db * db;
  assign err_sum = npcm_pkg::DistW'(sr) + npcm_pkg::DistW'(sg) + npcm_pkg::DistW'(sb);

  always_comb begin
    item_d = item_i;
    if (item_i.is_map && !item_i.done && (IdxC < item_i.count)
        && (err_sum < item_i.win_err)) begin
      item_d.win_err  = err_sum;
      item_d.win_slot = IdxS;
      item_d.done     = (err_sum == '0);
    end
  end

  // palette entry: written as a load transaction passes
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i && !item_i.is_map && (item_i.slot == IdxS)) begin
      pal_q <= item_i.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
